// ===== rtl/wsdf_pkg.sv =====
`default_nettype none
package wsdf_pkg;

  localparam int LEN_W = 63;
  localparam int HLEN_W = 16;
  localparam int ETYPE_W = 5;

  localparam logic [1:0] KIND_HDR_END = 2'd0;
  localparam logic [1:0] KIND_DESC    = 2'd1;
  localparam logic [1:0] KIND_PAY     = 2'd2;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [ETYPE_W-1:0] ETYPE_TEXT    = 5'd1;
  localparam logic [ETYPE_W-1:0] ETYPE_UNKNOWN = 5'd16;

  localparam logic [HLEN_W-1:0] HLEN_MAX = 16'hffff;

  // CR LF CR LF
  function automatic logic [7:0] term_byte(input logic [1:0] idx);
    term_byte = idx[0] ? CHAR_LF : CHAR_CR;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/websocket_frame_deframer_core.sv =====
// Channel  Signals                                             Direction
// in       in_valid, in_ready, in_byte, http_start             sink
// out      out_valid, out_ready, kind, frame_flags, opcode,    source
//          effective_type, is_text, masked, payload_length,
//          out_byte, last, header_length
//
// One byte per cycle while in_ready is high; any result shows the next cycle.
// Throughput is set by the parser state register and the single output register.
// in_ready drops only while a result is held and out_ready is low.
// rst (synchronous) returns the parser to HTTP header scan with type unknown.
`default_nettype none
module websocket_frame_deframer_core (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [7:0]                       in_byte,
  input  wire                              http_start,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [1:0]                       kind,
  output logic [3:0]                       frame_flags,
  output logic [3:0]                       opcode,
  output logic [wsdf_pkg::ETYPE_W-1:0]     effective_type,
  output logic                             is_text,
  output logic                             masked,
  output logic [wsdf_pkg::LEN_W-1:0]       payload_length,
  output logic [7:0]                       out_byte,
  output logic                             last,
  output logic [wsdf_pkg::HLEN_W-1:0]      header_length
);
  import wsdf_pkg::*;

  typedef enum logic [2:0] {
    MODE_HDR, MODE_B0, MODE_B1, MODE_EXT, MODE_MASK, MODE_PAY
  } mode_t;

  mode_t              mode, mode_next;
  logic [1:0]         term_match, term_match_next;
  logic [HLEN_W-1:0]  header_count, header_count_next;
  logic [3:0]         ext_byte_count, ext_byte_count_next;
  logic [3:0]         held_flags, held_flags_next;
  logic [3:0]         held_opcode, held_opcode_next;
  logic               held_mask, held_mask_next;
  logic [LEN_W-1:0]   length_accum, length_accum_next;
  logic [LEN_W-1:0]   remaining, remaining_next;
  logic [ETYPE_W-1:0] sticky_type, sticky_type_next;

  logic               emit;
  logic [1:0]         res_kind;
  logic               res_last;
  logic [7:0]         res_byte;
  logic [HLEN_W-1:0]  res_hlen;

  logic               take;
  mode_t              cur_mode;
  logic [1:0]         old_match;
  logic [HLEN_W-1:0]  cur_count;
  logic [2:0]         nw;
  logic [HLEN_W+1:0]  hsum;
  logic [3:0]         ext_dec;
  logic               do_finish;
  logic [LEN_W-1:0]   fin_len;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  always_comb begin
    mode_next           = mode;
    term_match_next     = term_match;
    header_count_next   = header_count;
    ext_byte_count_next = ext_byte_count;
    held_flags_next     = held_flags;
    held_opcode_next    = held_opcode;
    held_mask_next      = held_mask;
    length_accum_next   = length_accum;
    remaining_next      = remaining;
    sticky_type_next    = sticky_type;
    emit                = 1'b0;
    res_kind            = KIND_PAY;
    res_last            = 1'b0;
    res_byte            = '0;
    res_hlen            = '0;
    do_finish           = 1'b0;
    fin_len             = length_accum;
    nw                  = '0;
    hsum                = '0;
    ext_dec             = (ext_byte_count != 4'd0) ? ext_byte_count - 4'd1 : 4'd0;

    cur_mode  = http_start ? MODE_HDR : mode;
    old_match = http_start ? 2'd0 : term_match;
    cur_count = http_start ? '0 : header_count;
    if (http_start) begin
      ext_byte_count_next = '0;
      remaining_next      = '0;
      ext_dec             = '0;
    end

    unique case (cur_mode)
      MODE_B0: begin
        held_flags_next  = in_byte[7:4];
        held_opcode_next = in_byte[3:0];
        mode_next        = MODE_B1;
      end
      MODE_B1: begin
        held_mask_next = in_byte[7];
        if (in_byte[6:0] == LEN_EXT16) begin
          length_accum_next   = '0;
          ext_byte_count_next = EXT16_BYTES;
          mode_next           = MODE_EXT;
        end else if (in_byte[6:0] == LEN_EXT64) begin
          length_accum_next   = '0;
          ext_byte_count_next = EXT64_BYTES;
          mode_next           = MODE_EXT;
        end else begin
          length_accum_next = {{(LEN_W-7){1'b0}}, in_byte[6:0]};
          if (in_byte[7]) begin
            ext_byte_count_next = MASK_KEY_BYTES;
            mode_next           = MODE_MASK;
          end else begin
            do_finish = 1'b1;
            fin_len   = length_accum_next;
          end
        end
      end
      MODE_EXT: begin
        length_accum_next   = {length_accum[LEN_W-9:0], in_byte};
        ext_byte_count_next = ext_dec;
        if (ext_dec == 4'd0) begin
          if (held_mask) begin
            ext_byte_count_next = MASK_KEY_BYTES;
            mode_next           = MODE_MASK;
          end else begin
            do_finish = 1'b1;
            fin_len   = length_accum_next;
          end
        end
      end
      MODE_MASK: begin
        ext_byte_count_next = ext_dec;
        if (ext_dec == 4'd0) begin
          do_finish = 1'b1;
          fin_len   = length_accum;
        end
      end
      MODE_PAY: begin
        remaining_next = (remaining != '0) ? remaining - {{(LEN_W-1){1'b0}}, 1'b1} : '0;
        emit     = 1'b1;
        res_kind = KIND_PAY;
        res_byte = in_byte;
        res_last = (remaining_next == '0);
        if (res_last) begin
          mode_next = MODE_B0;
        end else begin
          mode_next = MODE_PAY;
        end
      end
      MODE_HDR: begin
        if (in_byte == term_byte(old_match)) begin
          nw = {1'b0, old_match} + 3'd1;
        end else begin
          nw = (in_byte == CHAR_CR) ? 3'd1 : 3'd0;
        end
        hsum = {2'b00, cur_count} + {{(HLEN_W-1){1'b0}}, ({1'b0, old_match} + 3'd1 - nw)};
        header_count_next = (hsum > {2'b00, HLEN_MAX}) ? HLEN_MAX : hsum[HLEN_W-1:0];
        if (nw == 3'd4) begin
          emit              = 1'b1;
          res_kind          = KIND_HDR_END;
          res_hlen          = header_count_next;
          header_count_next = '0;
          term_match_next   = '0;
          mode_next         = MODE_B0;
        end else begin
          term_match_next = nw[1:0];
          mode_next       = MODE_HDR;
        end
      end
      default: begin
        mode_next = MODE_HDR;
      end
    endcase

    if (do_finish) begin
      if (held_opcode_next != OP_CONT) begin
        sticky_type_next = {1'b0, held_opcode_next};
      end
      remaining_next = fin_len;
      emit           = 1'b1;
      res_kind       = KIND_DESC;
      res_last       = (fin_len == '0);
      mode_next      = (fin_len != '0) ? MODE_PAY : MODE_B0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_HDR;
      term_match     <= '0;
      header_count   <= '0;
      ext_byte_count <= '0;
      held_flags     <= '0;
      held_opcode    <= '0;
      held_mask      <= 1'b0;
      length_accum   <= '0;
      remaining      <= '0;
      sticky_type    <= ETYPE_UNKNOWN;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        mode           <= mode_next;
        term_match     <= term_match_next;
        header_count   <= header_count_next;
        ext_byte_count <= ext_byte_count_next;
        held_flags     <= held_flags_next;
        held_opcode    <= held_opcode_next;
        held_mask      <= held_mask_next;
        length_accum   <= length_accum_next;
        remaining      <= remaining_next;
        sticky_type    <= sticky_type_next;
      end
      if (in_ready) begin
        out_valid <= take && emit;
      end
    end
  end

  // result register, for header end, descriptor and payload beats
  always_ff @(posedge clk) begin
    if (take && emit) begin
      kind      <= res_kind;
      out_byte  <= res_byte;
      last      <= res_last;
      header_length <= res_hlen;
      if (res_kind == KIND_HDR_END) begin
        frame_flags    <= '0;
        opcode         <= '0;
        effective_type <= ETYPE_UNKNOWN;
        is_text        <= 1'b0;
        masked         <= 1'b0;
        payload_length <= '0;
      end else begin
        frame_flags    <= held_flags_next;
        opcode         <= held_opcode_next;
        effective_type <= sticky_type_next;
        is_text        <= (sticky_type_next == ETYPE_TEXT);
        masked         <= held_mask_next;
        payload_length <= length_accum_next;
      end
    end
  end

`ifndef SYNTH
  a_ext_count_live: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_EXT |-> ext_byte_count != 4'd0)
    else $error("extended length state with no bytes left");

  a_pay_remaining: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_PAY |-> remaining != '0)
    else $error("payload state with zero bytes remaining");

  a_pay_emits: assert property (@(posedge clk) disable iff (rst)
    take && !http_start && mode == MODE_PAY |=> out_valid && kind == KIND_PAY)
    else $error("payload beat not forwarded");

  a_hdr_end_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_HDR_END |->
      effective_type == ETYPE_UNKNOWN && payload_length == '0 && !last)
    else $error("header end beat carries frame fields");
`endif

endmodule
`default_nettype wire

// ===== tb/websocket_frame_deframer_core_tb.sv =====
`default_nettype none
module websocket_frame_deframer_core_tb;
  import wsdf_pkg::*;

  typedef enum logic [2:0] {
    SCAN_HDR,
    FRM_B0,
    FRM_B1,
    FRM_EXT,
    FRM_KEY,
    FRM_PAY
  } parse_mode_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         frame_flags;
    logic [3:0]         opcode;
    logic [ETYPE_W-1:0] effective_type;
    logic               is_text;
    logic               masked;
    logic [LEN_W-1:0]   payload_length;
    logic [7:0]         out_byte;
    logic               last;
    logic [HLEN_W-1:0]  header_length;
  } deframe_result_t;

  class deframe_scoreboard;
    parse_mode_t       mode;
    logic [1:0]        term_hits;
    int unsigned       hdr_count;
    logic [3:0]        ext_left;
    logic [3:0]        cur_flags;
    logic [3:0]        cur_opcode;
    logic              cur_mask;
    logic [63:0]       len_acc;
    logic [63:0]       bytes_left;
    logic [4:0]        sticky;
    deframe_result_t   expected_q[$];
    int                errors;
    int                checked;
    int                n_hdr;
    int                n_desc;
    int                n_pay;

    function new();
      mode = SCAN_HDR;
      term_hits = 0;
      hdr_count = 0;
      ext_left = 0;
      cur_flags = 0;
      cur_opcode = 0;
      cur_mask = 0;
      len_acc = 0;
      bytes_left = 0;
      sticky = ETYPE_UNKNOWN;
      errors = 0;
      checked = 0;
      n_hdr = 0;
      n_desc = 0;
      n_pay = 0;
    endfunction

    function void push_frame_result(logic [1:0] k, logic [7:0] ob, logic lst);
      deframe_result_t r;
      r.kind = k;
      r.frame_flags = cur_flags;
      r.opcode = cur_opcode;
      r.effective_type = sticky;
      r.is_text = (sticky == ETYPE_TEXT);
      r.masked = cur_mask;
      r.payload_length = len_acc[LEN_W-1:0];
      r.out_byte = ob;
      r.last = lst;
      r.header_length = '0;
      expected_q.push_back(r);
    endfunction

    function void close_header();
      if (cur_opcode != OP_CONT) sticky = {1'b0, cur_opcode};
      bytes_left = len_acc;
      push_frame_result(KIND_DESC, 8'h00, bytes_left == 0);
      mode = (bytes_left != 0) ? FRM_PAY : FRM_B0;
    endfunction

    function void length_done();
      if (cur_mask) begin
        ext_left = MASK_KEY_BYTES;
        mode = FRM_KEY;
      end else begin
        close_header();
      end
    endfunction

    // advance the parser by one accepted byte
    function void absorb_byte(logic [7:0] b, logic hs);
      logic [2:0]      nxt;
      logic [6:0]      l7;
      int unsigned     sum;
      deframe_result_t r;
      if (hs) begin
        mode = SCAN_HDR;
        term_hits = 0;
        hdr_count = 0;
        ext_left = 0;
        bytes_left = 0;
      end
      case (mode)
        FRM_B0: begin
          cur_flags = b[7:4];
          cur_opcode = b[3:0];
          mode = FRM_B1;
        end
        FRM_B1: begin
          l7 = b[6:0];
          cur_mask = b[7];
          len_acc = 0;
          if (l7 == LEN_EXT16) begin
            ext_left = EXT16_BYTES;
            mode = FRM_EXT;
          end else if (l7 == LEN_EXT64) begin
            ext_left = EXT64_BYTES;
            mode = FRM_EXT;
          end else begin
            len_acc = {57'd0, l7};
            length_done();
          end
        end
        FRM_EXT: begin
          len_acc = {len_acc[55:0], b};
          if (ext_left != 0) ext_left = ext_left - 1;
          if (ext_left == 0) begin
            len_acc[63] = 1'b0;
            length_done();
          end
        end
        FRM_KEY: begin
          if (ext_left != 0) ext_left = ext_left - 1;
          if (ext_left == 0) close_header();
        end
        FRM_PAY: begin
          if (bytes_left != 0) bytes_left = bytes_left - 1;
          push_frame_result(KIND_PAY, b, bytes_left == 0);
          if (bytes_left == 0) mode = FRM_B0;
        end
        default: begin
          if (b == (term_hits[0] ? CHAR_LF : CHAR_CR)) nxt = {1'b0, term_hits} + 3'd1;
          else nxt = (b == CHAR_CR) ? 3'd1 : 3'd0;
          sum = hdr_count + term_hits + 1 - nxt;
          hdr_count = (sum > HLEN_MAX) ? HLEN_MAX : sum;
          if (nxt == 3'd4) begin
            r = '0;
            r.kind = KIND_HDR_END;
            r.effective_type = ETYPE_UNKNOWN;
            r.header_length = hdr_count[HLEN_W-1:0];
            expected_q.push_back(r);
            hdr_count = 0;
            term_hits = 0;
            mode = FRM_B0;
          end else begin
            term_hits = nxt[1:0];
          end
        end
      endcase
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void match_result(deframe_result_t got);
      deframe_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, actual kind %0d", $time, got.kind);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.kind == KIND_HDR_END) n_hdr++;
      else if (want.kind == KIND_DESC) n_desc++;
      else n_pay++;
      cmp("kind", want.kind, got.kind);
      cmp("frame_flags", want.frame_flags, got.frame_flags);
      cmp("opcode", want.opcode, got.opcode);
      cmp("effective_type", want.effective_type, got.effective_type);
      cmp("is_text", want.is_text, got.is_text);
      cmp("masked", want.masked, got.masked);
      cmp("payload_length", want.payload_length, got.payload_length);
      cmp("out_byte", want.out_byte, got.out_byte);
      cmp("last", want.last, got.last);
      cmp("header_length", want.header_length, got.header_length);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_byte = 8'h00;
  logic                http_start = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          kind;
  logic [3:0]          frame_flags;
  logic [3:0]          opcode;
  logic [ETYPE_W-1:0]  effective_type;
  logic                is_text;
  logic                masked;
  logic [LEN_W-1:0]    payload_length;
  logic [7:0]          out_byte;
  logic                last;
  logic [HLEN_W-1:0]   header_length;

  deframe_scoreboard sb;
  int                beats_sent = 0;
  int                in_gap_max = 0;
  int                out_gap_max = 0;
  bit                need_hs = 1'b1;

  always #10 clk = ~clk;

  websocket_frame_deframer_core dut (.*);

  task automatic send_beat(input logic [7:0] b, input logic hs);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    http_start <= hs;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sb.absorb_byte(b, hs);
    beats_sent++;
  endtask

  task automatic send_frame(output bit cut);
    logic [3:0]  op;
    logic [3:0]  fl;
    logic [63:0] plen;
    logic        mask;
    logic [7:0]  b;
    int          sel;
    int          nsend;
    cut = 1'b0;
    case ($urandom_range(0, 9))
      0, 1, 2: op = OP_CONT;
      3, 4:    op = 4'h1;
      5:       op = 4'h2;
      6:       op = $urandom_range(8, 10);
      default: op = $urandom_range(0, 15);
    endcase
    fl = $urandom_range(0, 15);
    mask = $urandom_range(0, 1);
    send_beat({fl, op}, 1'b0);
    sel = $urandom_range(0, 11);
    if (sel <= 6) begin
      plen = (sel == 0) ? 64'd0 : (sel == 1) ? 64'd125 : 64'($urandom_range(1, 24));
      send_beat({mask, plen[6:0]}, 1'b0);
    end else if (sel <= 9) begin
      plen = (sel == 9) ? 64'($urandom_range(0, 65535)) : 64'($urandom_range(0, 40));
      send_beat({mask, LEN_EXT16}, 1'b0);
      send_beat(plen[15:8], 1'b0);
      send_beat(plen[7:0], 1'b0);
    end else begin
      plen = (sel == 10) ? 64'($urandom_range(0, 40)) : {$urandom, $urandom};
      send_beat({mask, LEN_EXT64}, 1'b0);
      for (int i = 7; i >= 0; i--) send_beat(plen[i*8 +: 8], 1'b0);
      plen[63] = 1'b0;
    end
    if (mask) repeat (4) begin
      b = $urandom_range(0, 255);
      send_beat(b, 1'b0);
    end
    // long frames are cut short; the next header start drops them
    if (plen > 300) begin
      nsend = $urandom_range(0, 4);
      cut = 1'b1;
    end else begin
      nsend = plen;
    end
    repeat (nsend) begin
      b = $urandom_range(0, 255);
      send_beat(b, 1'b0);
    end
  endtask

  task automatic send_terminator(input logic hs);
    send_beat(CHAR_CR, hs);
    send_beat(CHAR_LF, 1'b0);
    send_beat(CHAR_CR, 1'b0);
    send_beat(CHAR_LF, 1'b0);
  endtask

  task automatic run_session();
    int         hlen;
    int         nfr;
    logic [1:0] tm;
    logic [7:0] b;
    logic       hs;
    bit         cut;
    hlen = $urandom_range(0, 30);
    hs = need_hs || ($urandom_range(0, 7) != 0);
    need_hs = 1'b0;
    tm = 0;
    for (int i = 0; i < hlen; i++) begin
      case ($urandom_range(0, 5))
        0:       b = CHAR_CR;
        1:       b = CHAR_LF;
        default: b = $urandom_range(0, 255);
      endcase
      // keep the terminator from showing up early
      if (tm == 2'd3 && b == CHAR_LF) b = 8'h41;
      if (i == hlen - 1 && (b == CHAR_CR || b == CHAR_LF)) b = 8'h2f;
      if (b == (tm[0] ? CHAR_LF : CHAR_CR)) tm = tm + 1;
      else tm = (b == CHAR_CR) ? 2'd1 : 2'd0;
      send_beat(b, hs && i == 0);
    end
    send_terminator(hs && hlen == 0);
    nfr = $urandom_range(0, 6);
    for (int f = 0; f < nfr; f++) begin
      send_frame(cut);
      if (cut) begin
        need_hs = 1'b1;
        break;
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        b = $urandom_range(0, 255);
        send_beat(b, 1'b0);
      end
      need_hs = 1'b1;
    end
  endtask

  // result side
  initial begin
    deframe_result_t got;
    int              stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      got.kind = kind;
      got.frame_flags = frame_flags;
      got.opcode = opcode;
      got.effective_type = effective_type;
      got.is_text = is_text;
      got.masked = masked;
      got.payload_length = payload_length;
      got.out_byte = out_byte;
      got.last = last;
      got.header_length = header_length;
      @(posedge clk);
      sb.match_result(got);
    end
  end

  initial begin
    logic [7:0] seq[$];
    int         waited;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // overlapping terminator, zero-length text, continuation with 16-bit
    // length, all-ones 64-bit length with MSB dropped
    in_gap_max = 3;
    out_gap_max = 3;
    seq = '{8'h0d, 8'h0a, 8'h0d, 8'h0d, 8'h0a, 8'h0d, 8'h0a,
            8'h81, 8'h00,
            8'h00, 8'h7e, 8'h00, 8'h01, 8'hff,
            8'hf2, 8'h7f, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
            8'h00};
    send_beat(8'h48, 1'b1);
    foreach (seq[i]) send_beat(seq[i], 1'b0);

    while (beats_sent < 850) begin
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
      run_session();
    end
    in_valid <= 1'b0;
    http_start <= 1'b0;

    waited = 0;
    while (sb.expected_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected beats never arrived", $time, sb.expected_q.size());
    end
    $display("Sent %0d stream bytes; checked %0d results", beats_sent, sb.checked);
    $display("  header ends %0d, frame descriptors %0d, payload bytes %0d",
             sb.n_hdr, sb.n_desc, sb.n_pay);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
